// ----- hdl/slm_pkg.sv -----
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants for the sorted list merge block.
// ----------------------------------------------------------------------------
package slm_pkg;

	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	// Code 3 carries no meaning and is dropped.
	typedef enum logic [1:0] {
		KIND_FIRST  = 2'd0,
		KIND_SECOND = 2'd1,
		KIND_START  = 2'd2
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_first;
		logic load_second;
		logic start;
		logic emit;
		logic finish;
	} slm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_room;
		logic final_word;
	} slm_sts_t;

endpackage

// ----- hdl/sorted_list_merge.sv -----
// ----------------------------------------------------------------------------
// sorted_list_merge
// Stable two-way merge of two ascending lists of signed 32-bit words.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+------------------------------
//   in      | into      | in_valid/in_stall  | kind, value
//   out     | out of    | out_valid/out_stall| merged_value, last, empty_res
//
// Load words are taken while in_stall is low. Once started, the merge gives
// one result per cycle unless the output stalls (first count + second count
// results, one result when both lists are empty), set by the single
// compare-select step on the two store read ports. in_stall is high for the
// whole merge run. Reset clears the counts and control state; store contents
// stay undefined. A stall on the output holds the merge in place.
// ----------------------------------------------------------------------------
module sorted_list_merge #(
	parameter int LIST_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  slm_pkg::kind_t kind,
	input  slm_pkg::word_t value,
	output logic           out_valid,
	input  logic           out_stall,
	output slm_pkg::word_t merged_value,
	output logic           last,
	output logic           empty_res
);
	import slm_pkg::*;

	slm_cmd_t cmd;
	slm_sts_t sts;

	slm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	slm_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.merged_value (merged_value),
		.last         (last),
		.empty_res    (empty_res)
	);

endmodule

// ----- hdl/slm_ctrl.sv -----
// ----------------------------------------------------------------------------
// slm_ctrl
// Controller: takes load and start words while idle, then steps the merge
// one result per cycle while the output register has room.
// ----------------------------------------------------------------------------
module slm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  slm_pkg::kind_t   kind,
	output logic             in_stall,
	input  slm_pkg::slm_sts_t sts,
	output slm_pkg::slm_cmd_t cmd
);
	import slm_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   accept;

	assign in_stall = in_stall_q;
	assign accept   = in_valid && !in_stall_q;

	always_comb begin
		cmd             = '0;
		cmd.load_first  = accept && (kind == KIND_FIRST);
		cmd.load_second = accept && (kind == KIND_SECOND);
		cmd.start       = accept && (kind == KIND_START);
		cmd.emit        = (state_q == ST_MERGE) && sts.out_room;
		cmd.finish      = cmd.emit && sts.final_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q    <= ST_MERGE;
						in_stall_q <= 1'b1;
					end
				end
				ST_MERGE: begin
					if (cmd.finish) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ----- hdl/slm_dp.sv -----
// ----------------------------------------------------------------------------
// slm_dp
// Datapath: the two list stores, their fill counts, the merge read pointers,
// the compare-and-select step and the output register.
// ----------------------------------------------------------------------------
module slm_dp #(
	parameter int LIST_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slm_pkg::word_t    value,
	input  slm_pkg::slm_cmd_t cmd,
	output slm_pkg::slm_sts_t sts,
	output logic              out_valid,
	input  logic              out_stall,
	output slm_pkg::word_t    merged_value,
	output logic              last,
	output logic              empty_res
);
	import slm_pkg::*;

	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	word_t first_mem  [LIST_DEPTH];
	word_t second_mem [LIST_DEPTH];

	logic [CNT_W-1:0] first_cnt_q, second_cnt_q;
	logic [CNT_W-1:0] first_idx_q, second_idx_q;
	logic [CNT_W-1:0] first_idx_nxt, second_idx_nxt;
	logic [CNT_W-1:0] first_adv, second_adv;
	word_t            first_rd_q, second_rd_q;

	logic  first_full, second_full;
	logic  first_avail, second_avail;
	logic  both_empty;
	logic  take_first;
	logic  final_word;
	word_t sel_word;

	logic  out_valid_q;
	word_t merged_value_q;
	logic  last_q;
	logic  empty_q;

	assign first_full   = (first_cnt_q  >= CNT_W'(LIST_DEPTH));
	assign second_full  = (second_cnt_q >= CNT_W'(LIST_DEPTH));
	assign first_avail  = (first_idx_q  < first_cnt_q);
	assign second_avail = (second_idx_q < second_cnt_q);
	assign both_empty   = (first_cnt_q == '0) && (second_cnt_q == '0);

	always_comb begin
		if (first_avail && second_avail) begin
			// ties go to the first list to keep the merge stable
			take_first = (first_rd_q <= second_rd_q);
		end else begin
			take_first = first_avail;
		end
	end

	assign first_adv  = take_first ? first_idx_q + CNT_W'(1) : first_idx_q;
	assign second_adv = take_first ? second_idx_q : second_idx_q + CNT_W'(1);
	assign final_word = both_empty ||
		((first_adv == first_cnt_q) && (second_adv == second_cnt_q));
	assign sel_word   = take_first ? first_rd_q : second_rd_q;

	always_comb begin
		if (cmd.start) begin
			first_idx_nxt  = '0;
			second_idx_nxt = '0;
		end else if (cmd.emit) begin
			first_idx_nxt  = first_adv;
			second_idx_nxt = second_adv;
		end else begin
			first_idx_nxt  = first_idx_q;
			second_idx_nxt = second_idx_q;
		end
	end

	assign sts.out_room   = !out_valid_q || !out_stall;
	assign sts.final_word = final_word;

	// Stores: written on load, read into registers at the next pointer.
	always_ff @(posedge clk) begin
		if (cmd.load_first && !first_full) begin
			first_mem[first_cnt_q[ADDR_W-1:0]] <= value;
		end
		if (cmd.load_second && !second_full) begin
			second_mem[second_cnt_q[ADDR_W-1:0]] <= value;
		end
		first_rd_q  <= first_mem[first_idx_nxt[ADDR_W-1:0]];
		second_rd_q <= second_mem[second_idx_nxt[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			first_idx_q  <= '0;
			second_idx_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			first_idx_q  <= first_idx_nxt;
			second_idx_q <= second_idx_nxt;
			if (cmd.finish) begin
				first_cnt_q  <= '0;
				second_cnt_q <= '0;
			end else begin
				if (cmd.load_first && !first_full) begin
					first_cnt_q <= first_cnt_q + CNT_W'(1);
				end
				if (cmd.load_second && !second_full) begin
					second_cnt_q <= second_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			merged_value_q <= both_empty ? word_t'(0) : sel_word;
			last_q         <= final_word;
			empty_q        <= both_empty;
		end
	end

	assign out_valid    = out_valid_q;
	assign merged_value = merged_value_q;
	assign last         = last_q;
	assign empty_res    = empty_q;

endmodule

// ----- hdl/slm_checker.sv -----
// ----------------------------------------------------------------------------
// slm_checker
// Port-level checks on the sorted list merge block.
// ----------------------------------------------------------------------------
module slm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input slm_pkg::kind_t kind,
	input slm_pkg::word_t value,
	input logic           out_valid,
	input logic           out_stall,
	input slm_pkg::word_t merged_value,
	input logic           last,
	input logic           empty_res
);
	import slm_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(kind) && $stable(value))
		else $error("stalled input word changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(merged_value)
			&& $stable(last) && $stable(empty_res))
		else $error("stalled output word changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last && (merged_value == 32'sd0))
		else $error("empty result not marked last with zero value");

	a_start_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == KIND_START) |=> in_stall)
		else $error("input not stalled after start");

	a_mid_run_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input open while a merge run is unfinished");

endmodule

bind sorted_list_merge slm_checker u_slm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.kind         (kind),
	.value        (value),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.merged_value (merged_value),
	.last         (last),
	.empty_res    (empty_res)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_list_merge. Loads two lists word by word,
// starts the merge and compares every merged word with a stable two-way
// merge predicted here. Covers both lists empty, one side empty, ties,
// full-range extremes, loads into a full store, the unused kind, a long
// output hold that backs up the input, and random jobs under random idling.
// ----------------------------------------------------------------------------
module tb;
	import slm_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int HALF_PERIOD = 6;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 90;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		word_t merged_value;
		logic  last;
		logic  empty_res;
	} merge_word_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	kind_t  kind = KIND_FIRST;
	word_t  value = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	word_t  merged_value;
	logic   last;
	logic   empty_res;

	word_t       first_list[$];
	word_t       second_list[$];
	merge_word_t merge_expect[$];

	int fail_count = 0;
	int words_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	sorted_list_merge #(
		.LIST_DEPTH(LIST_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.merged_value(merged_value),
		.last(last),
		.empty_res(empty_res)
	);

	always #HALF_PERIOD clk = ~clk;

	// Update the list copies and queue the merged words for one accepted word.
	function automatic void predict_merge(input logic [1:0] k, input word_t v);
		int i, j, total;
		bit take_first;
		merge_word_t w;
		i = 0;
		j = 0;
		total = first_list.size() + second_list.size();
		if (k == KIND_FIRST) begin
			if (first_list.size() < LIST_DEPTH) first_list.push_back(v);
		end else if (k == KIND_SECOND) begin
			if (second_list.size() < LIST_DEPTH) second_list.push_back(v);
		end else if (k == KIND_START) begin
			if (total == 0) begin
				w.merged_value = '0;
				w.last = 1'b1;
				w.empty_res = 1'b1;
				merge_expect.push_back(w);
			end
			while (i < first_list.size() || j < second_list.size()) begin
				// ties go to the first list
				if (i < first_list.size() && j < second_list.size())
					take_first = first_list[i] <= second_list[j];
				else
					take_first = i < first_list.size();
				if (take_first) begin
					w.merged_value = first_list[i];
					i++;
				end else begin
					w.merged_value = second_list[j];
					j++;
				end
				w.last = (i + j == total);
				w.empty_res = 1'b0;
				merge_expect.push_back(w);
			end
			first_list.delete();
			second_list.delete();
		end
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 5) return 0;
		if (r < 80) return $urandom_range(6, 1);
		if (r < 92) return $urandom_range(16, 7);
		return $urandom_range(LIST_DEPTH + 3, LIST_DEPTH);
	endfunction

	function automatic void make_list(output word_t lst[$], input int n, input bit narrow,
		input bit ordered);
		word_t w;
		int p;
		lst.delete();
		repeat (n) begin
			w = narrow ? word_t'($urandom_range(8)) - 4 : word_t'($urandom);
			p = lst.size();
			// insertion sort on signed values
			if (ordered)
				while (p > 0 && lst[p-1] > w) p--;
			lst.insert(p, w);
		end
	endfunction

	task automatic send_word(input logic [1:0] k, input word_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= kind_t'(k);
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_merge(k, v);
	endtask

	// Interleave the loads of both lists at random, then start the merge.
	task automatic send_job(input word_t a[$], input word_t b[$], input int noise_pct);
		int ia, ib;
		ia = 0;
		ib = 0;
		while (ia < a.size() || ib < b.size()) begin
			if ($urandom_range(99) < noise_pct) send_word(KIND_UNUSED, word_t'($urandom));
			if (ib >= b.size() || (ia < a.size() && $urandom_range(1) == 0)) begin
				send_word(KIND_FIRST, a[ia]);
				ia++;
			end else begin
				send_word(KIND_SECOND, b[ib]);
				ib++;
			end
		end
		send_word(KIND_START, word_t'($urandom));
		words_sent += a.size() + b.size() + 1;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (merge_expect.size() != 0);
	endtask

	task automatic test_empty_merge();
		send_word(KIND_START, WORD_MAX);
	endtask

	task automatic test_unused_kind();
		word_t none[$];
		word_t b[$] = '{WORD_MAX};
		send_word(KIND_UNUSED, -32'sd3);
		send_job(none, b, 0);
	endtask

	// Fill the first store with extremes and ties, then one word too many.
	task automatic test_store_full();
		word_t a[$] = '{WORD_MIN, WORD_MIN, -32'sd1000000, -32'sd65536, -32'sd2, -32'sd1,
			32'sd0, 32'sd0, 32'sd1, 32'sd2, 32'sd255, 32'sd65536, 32'sd1000000,
			WORD_MAX - 1, WORD_MAX, WORD_MAX, WORD_MIN};
		word_t b[$] = '{WORD_MIN, 32'sd0, WORD_MAX};
		send_job(a, b, 0);
		wait_for_results();
	endtask

	// Hold the output long enough that a full merge backs up into the input.
	task automatic test_long_hold();
		word_t a[$], b[$];
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_asks++;
		make_list(a, LIST_DEPTH, 1'b0, 1'b1);
		make_list(b, LIST_DEPTH, 1'b0, 1'b1);
		send_job(a, b, 0);
		make_list(a, 3, 1'b1, 1'b1);
		make_list(b, 2, 1'b1, 1'b1);
		send_job(a, b, 0);
		wait_for_results();
	endtask

	task automatic test_random_jobs(input int send_pct, input int recv_pct, input int goal);
		word_t a[$], b[$];
		int first_word, style;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		first_word = words_sent;
		while (words_sent - first_word < goal) begin
			style = $urandom_range(99);
			// mostly sorted lists, some narrow for ties, a few unsorted
			make_list(a, pick_count(), style < 25, style >= 8);
			make_list(b, pick_count(), style < 25, style >= 8);
			send_job(a, b, (style % 10 == 0) ? 20 : 0);
		end
		wait_for_results();
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		merge_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (merge_expect.size() == 0) begin
				$error("merged word with none expected: value %0d last %0b empty_res %0b",
					merged_value, last, empty_res);
				fail_count++;
			end else begin
				want = merge_expect.pop_front();
				if (merged_value !== want.merged_value) begin
					$error("merged_value: expected %0d, got %0d", want.merged_value,
						merged_value);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					fail_count++;
				end
				if (empty_res !== want.empty_res) begin
					$error("empty_res: expected %0b, got %0b", want.empty_res, empty_res);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 31;
		recv_idle_pct = 82;
		test_empty_merge();
		test_unused_kind();
		test_store_full();
		test_long_hold();
		test_random_jobs(31, 82, 60);
		test_random_jobs(82, 31, 60);
		test_random_jobs(0, 0, 60);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
